### rtl/amlm_pkg.sv
// Package for the mean-absolute level meter: payload, job and configuration types,
// register indexes and fixed widths. No dependencies.
package amlm_pkg;

  localparam int SUM_W = 24;
  localparam int CNT_W = 9;
  localparam int SIL_W = 20;
  localparam int LVL_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [SIL_W-1:0] SIL_MAX = {SIL_W{1'b1}};

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_MID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE = 3'd5;

  // Item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] sample;
    logic               last_in_block;
  } item_t;

  typedef struct packed {
    logic [15:0]      mean_abs;
    logic [LVL_W-1:0] raw_level;
    logic [LVL_W-1:0] shown_level;
    logic             changed;
  } result_t;

  // Work handed from the front end to the back end
  typedef struct packed {
    logic             is_tick;
    logic             emit;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic             enable;
    logic [15:0]      threshold_low;
    logic [15:0]      threshold_mid;
    logic [15:0]      threshold_high;
    logic [15:0]      hold_floor;
    logic [SIL_W-1:0] silence_ticks;
  } cfg_t;

endpackage

### rtl/amlm_front.sv
// Front end of the level meter: accumulates sample magnitudes per block and
// queues block ends and ticks as jobs. Depends on amlm_pkg.
module amlm_front
  import amlm_pkg::*;
#(
  parameter int MAX_BLOCK = 320
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  enable,
  input  logic  accept,
  input  item_t item,
  output logic  push,
  output job_t  job
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

  logic [SUM_W-1:0] abs_sum;
  logic [SUM_W-1:0] abs_sum_next;
  logic [CNT_W-1:0] sample_count;
  logic [CNT_W-1:0] sample_count_next;
  logic [15:0]      mag;
  logic             counted;
  logic             block_end;

  // Magnitude of the sample; the most negative value maps to 32768
  assign mag = item.sample[15] ? (~item.sample + 16'd1) : item.sample;
  assign counted = sample_count < MAX_CNT;

  always_comb begin
    abs_sum_next = abs_sum;
    sample_count_next = sample_count;
    if (counted) begin
      abs_sum_next = abs_sum + SUM_W'(mag);
      sample_count_next = sample_count + CNT_W'(1);
    end
  end

  assign block_end = accept && (item.operation == OP_SAMPLE) && enable && item.last_in_block;
  assign push = accept && ((item.operation == OP_TICK) || block_end);

  // Build the job: ticks carry whether they produce a result
  always_comb begin
    job.is_tick = (item.operation == OP_TICK);
    job.emit = enable;
    job.sum = abs_sum_next;
    job.count = sample_count_next;
  end

  // Advance the accumulator, clear it at block end
  always_ff @(posedge clk) begin
    if (rst) begin
      abs_sum <= '0;
      sample_count <= '0;
    end else if (accept && (item.operation == OP_SAMPLE) && enable) begin
      if (item.last_in_block) begin
        abs_sum <= '0;
        sample_count <= '0;
      end else begin
        abs_sum <= abs_sum_next;
        sample_count <= sample_count_next;
      end
    end
  end

endmodule

### rtl/amlm_queue.sv
// Short job queue between the front and back ends of the level meter.
// Depends on amlm_pkg.
module amlm_queue
  import amlm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign empty = (fill == '0);
  assign full = (fill == (PTR_W+1)'(DEPTH));
  assign head = slots[rd_ptr];

  // Store requests at the tail
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + (PTR_W+1)'(1);
        2'b01:   fill <= fill - (PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/amlm_back.sv
// Back end of the level meter: divides block sums, quantizes with release hold,
// ages the silence counter and holds the result register. Depends on amlm_pkg.
module amlm_back
  import amlm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  job_t    head,
  input  logic    empty,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  divisor;

  logic [LVL_W-1:0]  prev_level;
  logic [SIL_W-1:0]  silence_counter;
  logic              heard_any;
  logic [LVL_W-1:0]  reported_level;
  logic              reported_valid;

  logic              out_free;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              rem_ge;
  logic [SIL_W-1:0]  sil_aged;
  logic [SUM_W-1:0]  mean;
  logic [LVL_W-1:0]  quant;
  logic [LVL_W-1:0]  level;
  logic              tick_now;
  logic              skip_now;
  logic              block_now;

  assign out_free = !result_valid || !result_stall;

  // One restoring division step
  assign rem_sh = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign rem_ge = (rem_sh >= {1'b0, divisor});

  assign sil_aged = (silence_counter != SIL_MAX) ? silence_counter + SIL_W'(1)
                                                 : silence_counter;

  // Quantize the mean, checking thresholds from high to low
  assign mean = (divisor != '0) ? quo : '0;
  always_comb begin
    priority if (mean > SUM_W'(cfg.threshold_high)) begin
      quant = 2'd3;
    end else if (mean > SUM_W'(cfg.threshold_mid)) begin
      quant = 2'd2;
    end else if (mean > SUM_W'(cfg.threshold_low)) begin
      quant = 2'd1;
    end else begin
      quant = 2'd0;
    end
  end

  // Release hold: keep the previous level on a one-step drop above the floor
  always_comb begin
    level = quant;
    if ((quant < prev_level) && ((prev_level - quant) == LVL_W'(1))
        && (mean > SUM_W'(cfg.hold_floor))) begin
      level = prev_level;
    end
  end

  assign tick_now = (state == S_IDLE) && !empty && head.is_tick && head.emit && out_free;
  assign skip_now = (state == S_IDLE) && !empty && head.is_tick && !head.emit;
  assign block_now = (state == S_IDLE) && !empty && !head.is_tick;
  assign pop = tick_now || skip_now || block_now;

  // Sequence jobs and run the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (block_now) begin
            state <= S_DIV;
            step <= '0;
          end
        end
        S_DIV: begin
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (block_now) begin
      quo <= head.sum;
      divisor <= head.count;
      rem <= '0;
    end else if (state == S_DIV) begin
      rem <= rem_ge ? rem_diff : rem_sh;
      quo <= {quo[SUM_W-2:0], rem_ge};
    end
  end

  // Level, silence and reporting state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= '0;
      silence_counter <= '0;
      heard_any <= 1'b0;
      reported_level <= '0;
      reported_valid <= 1'b0;
    end else if (tick_now || skip_now) begin
      silence_counter <= sil_aged;
      if (tick_now) begin
        reported_level <= prev_level;
        reported_valid <= 1'b1;
      end
    end else if ((state == S_DONE) && out_free) begin
      prev_level <= level;
      silence_counter <= '0;
      heard_any <= 1'b1;
      reported_level <= level;
      reported_valid <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tick_now || ((state == S_DONE) && out_free)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // A block end clears silence, marks a block heard and shows its level; a tick shows zero until then or once silent
  always_ff @(posedge clk) begin
    if (tick_now) begin
      result.mean_abs <= '0;
      result.raw_level <= prev_level;
      result.shown_level <= (!heard_any || (sil_aged > cfg.silence_ticks)) ? '0 : prev_level;
      result.changed <= !reported_valid || (reported_level != prev_level);
    end else if ((state == S_DONE) && out_free) begin
      result.mean_abs <= mean[15:0];
      result.raw_level <= level;
      result.shown_level <= level;
      result.changed <= !reported_valid || (reported_level != level);
    end
  end

endmodule

### rtl/audio_mean_abs_level_meter_top.sv
// Top level of the mean-absolute level meter: configuration registers, front end,
// job queue and back end. Depends on amlm_pkg, amlm_front, amlm_queue, amlm_back.
//
// Usage:
//   Items (PCM samples or ticks) enter on item/item_valid/item_stall; a request
//   is taken at a clock edge with item_valid high and item_stall low. Results
//   leave on result/result_valid/result_stall under the same rule.
//   Registers are written through cfg_write_en/cfg_index/cfg_data, one a cycle; the user must
//   write them only while the block is idle, which it does not enforce; indexes beyond the list are ignored.
// Timing:
//   Samples are taken one per cycle while item_stall is low. A block end is queued
//   and its mean is formed by a 24-step restoring divider; the result is then
//   written to the result register. A tick passes through the queue and is
//   registered in the result register. The back end takes one tick a cycle
//   while the result side keeps up, and takes no new job while a block end is in
//   the divider; a four entry queue absorbs bursts, and item_stall rises when
//   it is full.
// Reset:
//   rst is synchronous; it restores register defaults and clears all levels,
//   counters and the queue. A stalled result holds its value until taken, and
//   the back end waits while the result register is occupied.
module audio_mean_abs_level_meter_top
  import amlm_pkg::*;
#(
  parameter int MAX_BLOCK = 320
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  item_t                 item,
  input  logic                  item_valid,
  output logic                  item_stall,
  output result_t               result,
  output logic                  result_valid,
  input  logic                  result_stall
);

  cfg_t cfg;
  logic item_accept;
  logic q_push;
  job_t q_job;
  job_t q_head;
  logic q_pop;
  logic q_empty;
  logic q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b1;
      cfg.threshold_low <= 16'd400;
      cfg.threshold_mid <= 16'd1100;
      cfg.threshold_high <= 16'd2200;
      cfg.hold_floor <= 16'd250;
      cfg.silence_ticks <= SIL_W'(140000);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ENABLE:     cfg.enable <= cfg_data[0];
        REG_THR_LOW:    cfg.threshold_low <= cfg_data[15:0];
        REG_THR_MID:    cfg.threshold_mid <= cfg_data[15:0];
        REG_THR_HIGH:   cfg.threshold_high <= cfg_data[15:0];
        REG_HOLD_FLOOR: cfg.hold_floor <= cfg_data[15:0];
        REG_SILENCE:    cfg.silence_ticks <= cfg_data[SIL_W-1:0];
        default:        cfg <= cfg;
      endcase
    end
  end

  // Hold input requests while the queue is full
  assign item_stall = q_full;
  assign item_accept = item_valid && !item_stall;

  amlm_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .enable (cfg.enable),
    .accept (item_accept),
    .item   (item),
    .push   (q_push),
    .job    (q_job)
  );

  amlm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  amlm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (q_head),
    .empty        (q_empty),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  // A queued job never meets a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("job pushed into a full queue");

  // The back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  // A nonzero shown level always equals the raw level
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.shown_level != '0) |-> (result.shown_level == result.raw_level))
    else $error("shown level disagrees with raw level");

  // The mean never exceeds the largest sample magnitude
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.mean_abs <= 16'd32768))
    else $error("mean out of range");

  // No result is pending just after reset
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");
`endif

endmodule
